// ----- src/window_coefficient_generator_top_defines.svh -----
// Assertion macros for the window coefficient generator
`ifndef WINDOW_COEFFICIENT_GENERATOR_TOP_DEFINES_SVH
`define WINDOW_COEFFICIENT_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define WCG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while aresetn is low
`define WCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/wcg_pkg.sv -----
// Shared constants, types and arithmetic helpers of the window coefficient generator
`timescale 1ns / 1ps
package wcg_pkg;

    localparam int IDX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;
    localparam int KIND_W    = 3;
    localparam int LEN_W     = 17;
    localparam int M_W       = 16;
    localparam int RECIP_W   = 48;
    localparam int RH_W      = 24;
    localparam int Q_W       = 31;
    localparam int U_W       = 32;
    localparam int NST       = 19;
    localparam int COS_ST    = 12;
    localparam int COS_FIRST = 5;
    localparam int MAX_FRAME = 65536;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TLEN = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HAMMING  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HANNING  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BARTLETT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BLACKMAN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RECT     = 3'd4;

    localparam logic [LEN_W-1:0]  RST_WLEN = 17'd256;
    localparam logic [LEN_W-1:0]  RST_TLEN = 17'd512;
    localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(MAX_FRAME);

    localparam logic [COEF_W-1:0] Q15_ONE  = 16'd32768;
    localparam logic [Q_W-1:0]    Q30_ONE  = 31'h4000_0000;
    localparam logic [Q_W-1:0]    HALF_TURN_Q = 31'h2000_0000;
    localparam logic [Q_W-1:0]    PIHALF   = 31'd1686629713;
    localparam logic [Q_W-1:0]    HAM_BASE = 31'd85899346;
    localparam logic [28:0]       HAM_GAIN = 29'd493921239;
    localparam logic [26:0]       BLK_GAIN = 27'd85899346;

    localparam int SH_56 = 37;
    localparam int SH_72 = 38;
    localparam int SH_30 = 36;
    localparam int SH_42 = 37;
    localparam int SH_12 = 35;
    localparam int SH_20 = 36;
    localparam int SH_6  = 34;
    localparam logic [32:0] MAG_56 = 33'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [32:0] MAG_72 = 33'(((64'd1 << SH_72) + 64'd71) / 64'd72);
    localparam logic [32:0] MAG_30 = 33'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [32:0] MAG_42 = 33'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [32:0] MAG_12 = 33'(((64'd1 << SH_12) + 64'd11) / 64'd12);
    localparam logic [32:0] MAG_20 = 33'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [32:0] MAG_6  = 33'(((64'd1 << SH_6) + 64'd5) / 64'd6);

    typedef struct packed {
        logic              zero;
        logic              unit;
        logic [LEN_W-1:0]  bart;
    } wcg_side_t;

    function automatic logic [Q_W-1:0] div_k(input logic [Q_W-1:0] v,
                                             input logic [32:0] mag, input int sh);
        logic [63:0] p;
        p = {33'd0, v} * {31'd0, mag};
        return Q_W'(p >> sh);
    endfunction

    function automatic logic [Q_W-1:0] mul_q30(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [61:0] p;
        p = {31'd0, a} * {31'd0, b};
        return p[60:30];
    endfunction

    function automatic logic [COEF_W-1:0] q30_to_q15(input logic signed [33:0] w);
        logic [33:0] v;
        v = 34'(w + 34'sd16384) >> 15;
        if (w < 0) begin
            return '0;
        end
        if (v > {18'd0, Q15_ONE}) begin
            return Q15_ONE;
        end
        return v[COEF_W-1:0];
    endfunction

endpackage

// ----- src/wcg_cos.sv -----
// Pipelined one-minus-cosine of a 32-bit turn fraction, Q30 result
`timescale 1ns / 1ps
module wcg_cos (
    input  logic                          aclk,
    input  logic [wcg_pkg::COS_ST-1:0]    en,
    input  logic [31:0]                   ph,
    output logic [wcg_pkg::U_W-1:0]       u
);
    import wcg_pkg::*;

    logic [1:0]     quad_reg [0:10];
    logic           swap_reg [0:10];
    logic [Q_W-1:0] r_reg;
    logic [Q_W-1:0] x_reg    [1:9];
    logic [Q_W-1:0] x2_reg   [2:7];
    logic [Q_W-1:0] t1c_reg, t1s_reg, p1c_reg, p1s_reg;
    logic [Q_W-1:0] t2c_reg, t2s_reg, p2c_reg, p2s_reg;
    logic [Q_W-1:0] t3c_reg, t3s_reg, p3c_reg, p3s_reg;
    logic [Q_W-1:0] cv_reg, t4s_reg, cv2_reg, sv_reg;
    logic [U_W-1:0] u_reg;
    logic [Q_W-1:0] r_next, cr, sr;
    logic [U_W-1:0] u_next;

    always_comb begin
        r_next = {1'b0, ph[29:0]};
        if (r_next > HALF_TURN_Q) begin
            r_next = Q30_ONE - r_next;
        end
    end

    always_comb begin
        cr = swap_reg[10] ? sv_reg : cv2_reg;
        sr = swap_reg[10] ? cv2_reg : sv_reg;
        case (quad_reg[10])
            2'd0:    u_next = {1'b0, Q30_ONE} - {1'b0, cr};
            2'd1:    u_next = {1'b0, Q30_ONE} + {1'b0, sr};
            2'd2:    u_next = {1'b0, Q30_ONE} + {1'b0, cr};
            default: u_next = {1'b0, Q30_ONE} - {1'b0, sr};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            quad_reg[0] <= ph[31:30];
            swap_reg[0] <= ({1'b0, ph[29:0]} > HALF_TURN_Q);
            r_reg       <= r_next;
        end
        for (int j = 1; j <= 10; j++) begin
            if (en[j]) begin
                quad_reg[j] <= quad_reg[j-1];
                swap_reg[j] <= swap_reg[j-1];
            end
        end
        if (en[1]) x_reg[1] <= mul_q30(r_reg, PIHALF);
        for (int j = 2; j <= 9; j++) begin
            if (en[j]) x_reg[j] <= x_reg[j-1];
        end
        if (en[2]) x2_reg[2] <= mul_q30(x_reg[1], x_reg[1]);
        for (int j = 3; j <= 7; j++) begin
            if (en[j]) x2_reg[j] <= x2_reg[j-1];
        end
        if (en[3]) begin
            t1c_reg <= Q30_ONE - div_k(x2_reg[2], MAG_56, SH_56);
            t1s_reg <= Q30_ONE - div_k(x2_reg[2], MAG_72, SH_72);
        end
        if (en[4]) begin
            p1c_reg <= mul_q30(x2_reg[3], t1c_reg);
            p1s_reg <= mul_q30(x2_reg[3], t1s_reg);
        end
        if (en[5]) begin
            t2c_reg <= Q30_ONE - div_k(p1c_reg, MAG_30, SH_30);
            t2s_reg <= Q30_ONE - div_k(p1s_reg, MAG_42, SH_42);
        end
        if (en[6]) begin
            p2c_reg <= mul_q30(x2_reg[5], t2c_reg);
            p2s_reg <= mul_q30(x2_reg[5], t2s_reg);
        end
        if (en[7]) begin
            t3c_reg <= Q30_ONE - div_k(p2c_reg, MAG_12, SH_12);
            t3s_reg <= Q30_ONE - div_k(p2s_reg, MAG_20, SH_20);
        end
        if (en[8]) begin
            p3c_reg <= mul_q30(x2_reg[7], t3c_reg);
            p3s_reg <= mul_q30(x2_reg[7], t3s_reg);
        end
        if (en[9]) begin
            cv_reg  <= Q30_ONE - (p3c_reg >> 1);
            t4s_reg <= Q30_ONE - div_k(p3s_reg, MAG_6, SH_6);
        end
        if (en[10]) begin
            cv2_reg <= cv_reg;
            sv_reg  <= mul_q30(x_reg[9], t4s_reg);
        end
        if (en[11]) u_reg <= u_next;
    end

    assign u = u_reg;

endmodule

// ----- src/window_coefficient_generator_top.sv -----
// Top level of the window coefficient generator: config, reciprocal setup and pipeline
//
// Channel | Direction | Handshake             | Payload
// s_      | in        | s_tvalid / s_tready   | s_tdata[15:0] sample_index
// m_      | out       | m_tvalid / m_tready   | m_tdata[15:0] coefficient, Q1.15
// cfg_    | in        | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[16:0]
//
// One word per cycle through the stage pipeline, while m_tready is high and the divider is idle.
// After reset and after every config write a bit-serial divider forms 2^48 / (L - 1);
// s_tready stays low meanwhile. cfg_ready is always high.
// Reset (aresetn, synchronous) clears valid bits and config to Hamming, 256, 512.
// A stalled m_ side holds its word; empty stages upstream still fill.
`timescale 1ns / 1ps
`include "window_coefficient_generator_top_defines.svh"
module window_coefficient_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wcg_pkg::IDX_W-1:0]       s_tdata,   // [15:0] sample_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wcg_pkg::COEF_W-1:0]      m_tdata,   // [15:0] coefficient
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wcg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wcg_pkg::CFG_W-1:0]       cfg_data
);
    import wcg_pkg::*;

    localparam int BART_ST = 4;

    logic [KIND_W-1:0]  kind_reg;
    logic [LEN_W-1:0]   wlen_reg, tlen_reg;
    logic [LEN_W-1:0]   len_min, len, half;
    logic [M_W-1:0]     mlen;

    logic               busy_reg;
    logic [5:0]         cnt_reg;
    logic [M_W-1:0]     rem_reg, rem_next;
    logic [RECIP_W-1:0] recip_reg;
    logic [M_W:0]       rr;
    logic               qbit;

    logic [NST-1:0]     vld_reg;
    logic [NST-1:0]     adv;
    wcg_side_t          sd_reg [0:NST-2];
    wcg_side_t          sd_in;

    logic [M_W-1:0]     b1_next, b2_next, k_next;
    logic [LEN_W-1:0]   n2;
    logic [M_W-1:0]     b1_reg, b2_reg;
    logic [31:0]        y_reg;
    logic [39:0]        a1h_reg, a1l_reg, a2h_reg, a2l_reg;
    logic [55:0]        yh_reg, yl_reg;
    logic [17:0]        ylo_reg [1:3];
    logic [63:0]        sum1, sum2;
    logic [79:0]        sumy;
    logic [31:0]        q1_reg [2:3];
    logic [31:0]        q2_reg [2:3];
    logic [16:0]        qb_reg [2:3];
    logic [35:0]        mq1, mq2, mqb;
    logic [17:0]        mq1_reg, mq2_reg, mqb_reg;
    logic [17:0]        r1, r2, rb;
    logic [16:0]        vb;
    logic [LEN_W-1:0]   bart_next;
    logic [31:0]        ph1_reg, ph2_reg;
    logic [U_W-1:0]     u1, u2;
    logic [U_W-1:0]     u1w_reg;
    logic [Q_W-1:0]     hm_reg, pb_reg;
    logic [60:0]        hm_prod, pb_prod;
    logic signed [33:0] w_ham, w_hann, w_blk;
    logic [COEF_W-1:0]  coef_next, coef_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_HAMMING;
            wlen_reg <= RST_WLEN;
            tlen_reg <= RST_TLEN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KIND: kind_reg <= cfg_data[KIND_W-1:0];
                CFG_WLEN: wlen_reg <= cfg_data;
                CFG_TLEN: tlen_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        len_min = (tlen_reg < wlen_reg) ? tlen_reg : wlen_reg;
        len     = (LEN_CAP < len_min) ? LEN_CAP : len_min;
        mlen    = M_W'(len - 17'd1);
        half    = len >> 1;
    end

    always_comb begin
        rr   = {rem_reg, (cnt_reg == 6'd0)};
        qbit = (rr >= {1'b0, mlen});
        rem_next = qbit ? M_W'(rr - {1'b0, mlen}) : rr[M_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else if (cfg_valid) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd48) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            recip_reg <= {recip_reg[RECIP_W-2:0], qbit};
        end
    end

    always_comb begin
        adv[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0] && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_tvalid && !busy_reg;
            for (int i = 1; i < NST; i++) begin
                if (adv[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_comb begin
        b1_next = (s_tdata >= mlen) ? s_tdata - mlen : s_tdata;
        n2      = {s_tdata, 1'b0};
        if (n2 >= {mlen, 1'b0}) begin
            b2_next = M_W'(n2 - {mlen, 1'b0});
        end else if (n2 >= {1'b0, mlen}) begin
            b2_next = M_W'(n2 - {1'b0, mlen});
        end else begin
            b2_next = n2[M_W-1:0];
        end
        k_next     = ({1'b0, s_tdata} < half) ? s_tdata : mlen - s_tdata;
        sd_in.zero = ({1'b0, s_tdata} >= len);
        sd_in.unit = (len == 17'd1);
        sd_in.bart = '0;
    end

    always_comb begin
        sum1 = {a1h_reg, 24'd0} + {24'd0, a1l_reg};
        sum2 = {a2h_reg, 24'd0} + {24'd0, a2l_reg};
        sumy = {yh_reg, 24'd0} + {24'd0, yl_reg};
        mq1  = q1_reg[2][17:0] * {2'd0, mlen};
        mq2  = q2_reg[2][17:0] * {2'd0, mlen};
        mqb  = {1'b0, qb_reg[2]} * {2'd0, mlen};
        r1   = 18'd0 - mq1_reg;
        r2   = 18'd0 - mq2_reg;
        rb   = ylo_reg[3] - mqb_reg;
        vb   = qb_reg[3] + {16'd0, (rb >= {2'd0, mlen})};
        bart_next = (vb > {1'b0, Q15_ONE}) ? {1'b0, Q15_ONE} : vb;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            b1_reg    <= b1_next;
            b2_reg    <= b2_next;
            y_reg     <= {k_next, 16'd0} + {17'd0, mlen[M_W-1:1]};
            sd_reg[0] <= sd_in;
        end
        for (int i = 1; i < NST - 1; i++) begin
            if (adv[i]) begin
                if (i == BART_ST) begin
                    sd_reg[i] <= '{zero: sd_reg[i-1].zero, unit: sd_reg[i-1].unit,
                                   bart: bart_next};
                end else begin
                    sd_reg[i] <= sd_reg[i-1];
                end
            end
        end
        if (adv[1]) begin
            a1h_reg    <= b1_reg * recip_reg[RECIP_W-1:RH_W];
            a1l_reg    <= b1_reg * recip_reg[RH_W-1:0];
            a2h_reg    <= b2_reg * recip_reg[RECIP_W-1:RH_W];
            a2l_reg    <= b2_reg * recip_reg[RH_W-1:0];
            yh_reg     <= y_reg * recip_reg[RECIP_W-1:RH_W];
            yl_reg     <= y_reg * recip_reg[RH_W-1:0];
            ylo_reg[1] <= y_reg[17:0];
        end
        if (adv[2]) begin
            q1_reg[2]  <= sum1[47:16];
            q2_reg[2]  <= sum2[47:16];
            qb_reg[2]  <= sumy[64:48];
            ylo_reg[2] <= ylo_reg[1];
        end
        if (adv[3]) begin
            mq1_reg    <= mq1[17:0];
            mq2_reg    <= mq2[17:0];
            mqb_reg    <= mqb[17:0];
            q1_reg[3]  <= q1_reg[2];
            q2_reg[3]  <= q2_reg[2];
            qb_reg[3]  <= qb_reg[2];
            ylo_reg[3] <= ylo_reg[2];
        end
        if (adv[4]) begin
            ph1_reg <= q1_reg[3] + {31'd0, (r1 >= {2'd0, mlen})};
            ph2_reg <= q2_reg[3] + {31'd0, (r2 >= {2'd0, mlen})};
        end
    end

    wcg_cos u_cos1 (
        .aclk (aclk),
        .en   (adv[COS_FIRST+COS_ST-1:COS_FIRST]),
        .ph   (ph1_reg),
        .u    (u1)
    );

    wcg_cos u_cos2 (
        .aclk (aclk),
        .en   (adv[COS_FIRST+COS_ST-1:COS_FIRST]),
        .ph   (ph2_reg),
        .u    (u2)
    );

    always_comb begin
        hm_prod = {3'd0, HAM_GAIN} * {29'd0, u1};
        pb_prod = {5'd0, BLK_GAIN} * {29'd0, u2};
    end

    always_ff @(posedge aclk) begin
        if (adv[NST-2]) begin
            hm_reg  <= hm_prod[60:30];
            pb_reg  <= pb_prod[60:30];
            u1w_reg <= u1;
        end
    end

    always_comb begin
        w_ham  = $signed({3'd0, HAM_BASE}) + $signed({3'd0, hm_reg});
        w_hann = $signed({3'd0, u1w_reg[U_W-1:1]});
        w_blk  = w_hann - $signed({3'd0, pb_reg});
        if (sd_reg[NST-2].zero) begin
            coef_next = '0;
        end else if (sd_reg[NST-2].unit) begin
            coef_next = Q15_ONE;
        end else begin
            case (kind_reg)
                KIND_RECT:     coef_next = Q15_ONE;
                KIND_BARTLETT: coef_next = sd_reg[NST-2].bart[COEF_W-1:0];
                KIND_HANNING:  coef_next = q30_to_q15(w_hann);
                KIND_BLACKMAN: coef_next = q30_to_q15(w_blk);
                default:       coef_next = q30_to_q15(w_ham);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NST-1]) begin
            coef_reg <= coef_next;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = coef_reg;

    `WCG_ASSERT_NOW(a_busy_blocks_input, busy_reg, !s_tready, "word taken during divider setup")
    `WCG_ASSERT_NOW(a_coef_in_range, m_tvalid, m_tdata <= Q15_ONE, "coefficient above one")
    `WCG_ASSERT_NEXT(a_cfg_restarts_div, cfg_valid, busy_reg, "config write left divider idle")

endmodule
